FILE: rtl/rmdp_pkg.sv
package rmdp_pkg;

  // Longest directive keyword, in characters
  localparam int KW_MAX   = 9;
  localparam int KW_COUNT = 10;

  // Flag set: five 2-bit codes, code i at bits 2i+1..2i
  localparam int FLAG_COUNT = 5;
  localparam int FLAG_W     = 2 * FLAG_COUNT;

  localparam logic [1:0] CODE_UNSET    = 2'd0;
  localparam logic [1:0] CODE_DISALLOW = 2'd1;
  localparam logic [1:0] CODE_ALLOW    = 2'd2;

  localparam int FLAG_INDEX   = 0;
  localparam int FLAG_FOLLOW  = 1;
  localparam int FLAG_ARCHIVE = 2;
  localparam int FLAG_DIR     = 3;
  localparam int FLAG_CATALOG = 4;

  // Delimiter bytes
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Classified token: which keyword the token matched, if any
  typedef enum logic [3:0] {
    KW_NOMATCH   = 4'd0,
    KW_ALL       = 4'd1,
    KW_NONE      = 4'd2,
    KW_INDEX     = 4'd3,
    KW_NOINDEX   = 4'd4,
    KW_FOLLOW    = 4'd5,
    KW_NOFOLLOW  = 4'd6,
    KW_ARCHIVE   = 4'd7,
    KW_NOARCHIVE = 4'd8,
    KW_NODIR     = 4'd9,
    KW_NOCAT     = 4'd10
  } kw_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              first_byte;
    logic              last_byte;
    logic              mode;
    logic [FLAG_W-1:0] robots_prior;
    logic [FLAG_W-1:0] engine_prior;
  } in_item_t;

  typedef struct packed {
    logic [FLAG_W-1:0] robots_flags;
    logic [FLAG_W-1:0] engine_flags;
  } out_item_t;

  // Word passed from the front end to the flag engine
  typedef struct packed {
    kw_t               kw;
    logic              first;
    logic              last;
    logic              mode;
    logic [FLAG_W-1:0] robots_prior;
    logic [FLAG_W-1:0] engine_prior;
  } q_entry_t;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == CH_SEMI) || (b == CH_COMMA) || (b == CH_SPACE) || (b == CH_TAB) ||
           (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ? (c - CASE_GAP) : c;
  endfunction

  // Keyword text, first character in the most significant used byte
  function automatic logic [8*KW_MAX-1:0] kw_text(input kw_t k);
    logic [8*KW_MAX-1:0] t;
    t = '0;
    case (k)
      KW_ALL:       t = 72'(24'h414C4C);
      KW_NONE:      t = 72'(32'h4E4F4E45);
      KW_INDEX:     t = 72'(40'h494E444558);
      KW_NOINDEX:   t = 72'(56'h4E4F494E444558);
      KW_FOLLOW:    t = 72'(48'h464F4C4C4F57);
      KW_NOFOLLOW:  t = 72'(64'h4E4F464F4C4C4F57);
      KW_ARCHIVE:   t = 72'(56'h41524348495645);
      KW_NOARCHIVE: t = 72'h4E4F41524348495645;
      KW_NODIR:     t = 72'(40'h4E4F4F4450);
      KW_NOCAT:     t = 72'(48'h4E4F59414341);
      default:      t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input kw_t k);
    logic [3:0] n;
    case (k)
      KW_ALL:       n = 4'd3;
      KW_NONE:      n = 4'd4;
      KW_INDEX:     n = 4'd5;
      KW_NOINDEX:   n = 4'd7;
      KW_FOLLOW:    n = 4'd6;
      KW_NOFOLLOW:  n = 4'd8;
      KW_ARCHIVE:   n = 4'd7;
      KW_NOARCHIVE: n = 4'd9;
      KW_NODIR:     n = 4'd5;
      KW_NOCAT:     n = 4'd6;
      default:      n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/robots_meta_directive_parser_top.sv
// Robots meta directive parser. Takes one byte of a robots or engine-specific meta value per
// word on the item channel (first_byte loads the prior flag sets, last_byte closes the value)
// and returns one result word with the merged robots and engine flag sets for each value.
// Throughput is one byte per clock unless the queue or the output register stalls: the front
// end classifies each token with a combinational parallel keyword compare, a two-entry queue
// decouples it from the flag engine, and the flag engine applies one directive per clock into
// a registered output. The result word passes through a queue slot and then the output
// register. Tokens longer than TOKEN_CHARS characters match nothing.
module robots_meta_directive_parser_top #(
  parameter int TOKEN_CHARS = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  rmdp_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output rmdp_pkg::out_item_t result
);

  logic               push_valid, push_ready;
  rmdp_pkg::q_entry_t push_entry;
  logic               pop_valid, pop_ready;
  rmdp_pkg::q_entry_t pop_entry;

  rmdp_front #(
    .TOKEN_CHARS(TOKEN_CHARS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  rmdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  rmdp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: rtl/rmdp_front.sv
module rmdp_front #(
  parameter int TOKEN_CHARS = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  rmdp_pkg::in_item_t  item,
  output logic                push_valid,
  input  logic                push_ready,
  output rmdp_pkg::q_entry_t  push_entry
);

  localparam int LW = $clog2(TOKEN_CHARS + 1);
  localparam int IW = (TOKEN_CHARS > 1) ? $clog2(TOKEN_CHARS) : 1;

  logic [7:0]    token_chars [TOKEN_CHARS];
  logic [LW-1:0] token_length, token_length_next;
  logic          token_overflow, token_overflow_next;

  logic          accept;
  logic          delim;
  logic [LW-1:0] len0;
  logic          ovf0;
  logic          fits;
  logic [LW-1:0] end_len;
  logic          end_ovf;
  logic [7:0]    view [rmdp_pkg::KW_MAX];
  rmdp_pkg::kw_t kw_hit;

  assign accept     = item_valid && push_ready;
  assign item_ready = push_ready;
  assign push_valid = item_valid;

  // Token state as seen by this byte (a first byte starts clean)
  assign delim = rmdp_pkg::is_delim(item.data_byte);
  assign len0  = item.first_byte ? '0 : token_length;
  assign ovf0  = item.first_byte ? 1'b0 : token_overflow;
  assign fits  = (len0 < LW'(TOKEN_CHARS));

  // Length and overflow of the token that ends on this byte
  always_comb begin
    if (delim) begin
      end_len = len0;
      end_ovf = ovf0;
    end else if (fits) begin
      end_len = len0 + LW'(1);
      end_ovf = ovf0;
    end else begin
      end_len = len0;
      end_ovf = 1'b1;
    end
  end

  // Token characters with the current byte folded in
  always_comb begin
    for (int i = 0; i < rmdp_pkg::KW_MAX; i++) begin
      if (!delim && fits && (len0 == LW'(i))) view[i] = item.data_byte;
      else                                     view[i] = token_chars[i];
    end
  end

  // Parallel keyword compare; lowest code wins
  always_comb begin
    kw_hit = rmdp_pkg::KW_NOMATCH;
    for (int k = rmdp_pkg::KW_COUNT; k >= 1; k--) begin
      logic                          same;
      logic [3:0]                    n;
      logic [8*rmdp_pkg::KW_MAX-1:0] txt;
      n    = rmdp_pkg::kw_len(rmdp_pkg::kw_t'(k));
      txt  = rmdp_pkg::kw_text(rmdp_pkg::kw_t'(k));
      same = !end_ovf && (8'(end_len) == 8'(n));
      for (int i = 0; i < rmdp_pkg::KW_MAX; i++) begin
        if (i < int'(n)) begin
          if (rmdp_pkg::to_upper(view[i]) != txt[8*(int'(n)-1-i) +: 8]) same = 1'b0;
        end
      end
      if (same) kw_hit = rmdp_pkg::kw_t'(k);
    end
  end

  always_comb begin
    push_entry.kw           = (delim || item.last_byte) ? kw_hit : rmdp_pkg::KW_NOMATCH;
    push_entry.first        = item.first_byte;
    push_entry.last         = item.last_byte;
    push_entry.mode         = item.mode;
    push_entry.robots_prior = item.robots_prior;
    push_entry.engine_prior = item.engine_prior;
  end

  // Token bookkeeping
  always_comb begin
    if (delim || item.last_byte) begin
      token_length_next   = '0;
      token_overflow_next = 1'b0;
    end else begin
      token_length_next   = end_len;
      token_overflow_next = end_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_length   <= '0;
      token_overflow <= 1'b0;
    end else if (accept) begin
      token_length   <= token_length_next;
      token_overflow <= token_overflow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !delim && fits) token_chars[len0[IW-1:0]] <= item.data_byte;
  end

endmodule

FILE: rtl/rmdp_queue.sv
module rmdp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  rmdp_pkg::q_entry_t push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output rmdp_pkg::q_entry_t pop_entry
);

  // Two-entry FIFO between the classifier and the flag engine
  rmdp_pkg::q_entry_t slots [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

FILE: rtl/rmdp_back.sv
module rmdp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  rmdp_pkg::q_entry_t  pop_entry,
  output logic                result_valid,
  input  logic                result_ready,
  output rmdp_pkg::out_item_t result
);

  localparam int FW = rmdp_pkg::FLAG_W;

  logic [FW-1:0] working_flags, working_flags_next;
  logic [FW-1:0] other_flags, other_flags_next;
  logic          value_mode, value_mode_next;

  logic          do_pop;
  logic [FW-1:0] w_cur, o_cur, w_upd, merged;
  logic [FW-1:0] rob_out, eng_out;

  function automatic logic [FW-1:0] set_allow(input logic [FW-1:0] f, input int i);
    logic [FW-1:0] r;
    r = f;
    r[2*i +: 2] = rmdp_pkg::CODE_ALLOW;
    return r;
  endfunction

  function automatic logic [FW-1:0] set_deny(input logic [FW-1:0] f, input int i);
    logic [FW-1:0] r;
    r = f;
    if (f[2*i +: 2] != rmdp_pkg::CODE_ALLOW) r[2*i +: 2] = rmdp_pkg::CODE_DISALLOW;
    return r;
  endfunction

  // Engine codes that are set override the robots codes
  function automatic logic [FW-1:0] merge(input logic [FW-1:0] rob, input logic [FW-1:0] eng);
    logic [FW-1:0] r;
    r = rob;
    for (int i = 0; i < rmdp_pkg::FLAG_COUNT; i++) begin
      if (eng[2*i +: 2] != rmdp_pkg::CODE_UNSET) r[2*i +: 2] = eng[2*i +: 2];
    end
    return r;
  endfunction

  // A last-byte word needs room in the output register
  assign pop_ready = !pop_entry.last || !result_valid || result_ready;
  assign do_pop    = pop_valid && pop_ready;

  // Load priors on a first byte, else continue from held sets
  always_comb begin
    if (pop_entry.first) begin
      value_mode_next = pop_entry.mode;
      w_cur = pop_entry.mode ? pop_entry.engine_prior : pop_entry.robots_prior;
      o_cur = pop_entry.mode ? pop_entry.robots_prior : pop_entry.engine_prior;
    end else begin
      value_mode_next = value_mode;
      w_cur = working_flags;
      o_cur = other_flags;
    end
  end

  // Directive effect on the working set
  always_comb begin
    case (pop_entry.kw)
      rmdp_pkg::KW_ALL:
        w_upd = set_allow(set_allow(w_cur, rmdp_pkg::FLAG_INDEX), rmdp_pkg::FLAG_FOLLOW);
      rmdp_pkg::KW_NONE:
        w_upd = set_deny(set_deny(w_cur, rmdp_pkg::FLAG_INDEX), rmdp_pkg::FLAG_FOLLOW);
      rmdp_pkg::KW_INDEX:     w_upd = set_allow(w_cur, rmdp_pkg::FLAG_INDEX);
      rmdp_pkg::KW_NOINDEX:   w_upd = set_deny(w_cur, rmdp_pkg::FLAG_INDEX);
      rmdp_pkg::KW_FOLLOW:    w_upd = set_allow(w_cur, rmdp_pkg::FLAG_FOLLOW);
      rmdp_pkg::KW_NOFOLLOW:  w_upd = set_deny(w_cur, rmdp_pkg::FLAG_FOLLOW);
      rmdp_pkg::KW_ARCHIVE:   w_upd = set_allow(w_cur, rmdp_pkg::FLAG_ARCHIVE);
      rmdp_pkg::KW_NOARCHIVE: w_upd = set_deny(w_cur, rmdp_pkg::FLAG_ARCHIVE);
      rmdp_pkg::KW_NODIR:     w_upd = set_deny(w_cur, rmdp_pkg::FLAG_DIR);
      rmdp_pkg::KW_NOCAT:     w_upd = set_deny(w_cur, rmdp_pkg::FLAG_CATALOG);
      default:                w_upd = w_cur;
    endcase
  end

  // End of value: merge and write back
  always_comb begin
    merged  = value_mode_next ? merge(o_cur, w_upd) : merge(w_upd, o_cur);
    rob_out = merged;
    eng_out = value_mode_next ? w_upd : o_cur;
    if (pop_entry.last) begin
      working_flags_next = value_mode_next ? w_upd : merged;
      other_flags_next   = value_mode_next ? merged : o_cur;
    end else begin
      working_flags_next = w_upd;
      other_flags_next   = o_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      working_flags <= '0;
      other_flags   <= '0;
      value_mode    <= 1'b0;
    end else if (do_pop) begin
      working_flags <= working_flags_next;
      other_flags   <= other_flags_next;
      value_mode    <= value_mode_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (do_pop && pop_entry.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_entry.last) begin
      result.robots_flags <= rob_out;
      result.engine_flags <= eng_out;
    end
  end

endmodule

FILE: rtl/rmdp_checker.sv
module rmdp_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input rmdp_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_ready,
  input rmdp_pkg::out_item_t result
);

  logic merge_ok;

  // Any set engine code must show up in the robots set
  always_comb begin
    merge_ok = 1'b1;
    for (int i = 0; i < rmdp_pkg::FLAG_COUNT; i++) begin
      if ((result.engine_flags[2*i +: 2] != rmdp_pkg::CODE_UNSET) &&
          (result.robots_flags[2*i +: 2] != result.engine_flags[2*i +: 2])) merge_ok = 1'b0;
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_merge: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> merge_ok)
    else $error("engine flags not merged into robots flags");

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("item word changed while waiting");

endmodule

bind robots_meta_directive_parser_top rmdp_checker u_rmdp_checker (.*);

FILE: sim/tb_top.sv
module tb_top;
  import rmdp_pkg::*;

  localparam int TOK_CHARS    = 9;
  localparam int ITEMS_TARGET = 1850;
  localparam int CALM_TAIL    = 200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_SPAN    = 400;
  localparam int PAUSE_AT     = 1100;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 2000;
  localparam int DIR_N        = 21;

  // Keyword spelling, first character in the top used byte, indexed by kw_t
  localparam logic [71:0] KW_TXT [11] = '{
    72'h0, 72'h414C4C, 72'h4E4F4E45, 72'h494E444558, 72'h4E4F494E444558,
    72'h464F4C4C4F57, 72'h4E4F464F4C4C4F57, 72'h41524348495645,
    72'h4E4F41524348495645, 72'h4E4F4F4450, 72'h4E4F59414341
  };
  localparam int KW_LEN [11] = '{0, 3, 4, 5, 7, 6, 8, 7, 9, 5, 6};

  localparam logic [7:0] SEPS [7] = '{CH_SEMI, CH_COMMA, CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_NUL};

  // Directed rows: text is kept apart, in dir_text
  typedef struct packed {
    logic              first_on;
    logic              mode;
    logic [FLAG_W-1:0] rp;
    logic [FLAG_W-1:0] ep;
    logic              chk;
    out_item_t         want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h000, 10'h000}},  // empty value
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h00A, 10'h000}},
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h005, 10'h000}},
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h002, 10'h000}},
    '{1'b1, 1'b0, 10'h3FF, 10'h000, 1'b1, '{10'h3FD, 10'h000}},  // code three denied
    '{1'b1, 1'b1, 10'h000, 10'h000, 1'b1, '{10'h008, 10'h008}},
    '{1'b1, 1'b1, 10'h3FF, 10'h3FF, 1'b1, '{10'h3F7, 10'h3F7}},
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h020, 10'h000}},
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h010, 10'h000}},
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h040, 10'h000}},
    '{1'b1, 1'b1, 10'h000, 10'h000, 1'b1, '{10'h100, 10'h100}},
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h000, 10'h000}},  // long token
    '{1'b1, 1'b0, 10'h000, 10'h000, 1'b1, '{10'h00A, 10'h000}},  // semicolon, comma, tab, CR and LF delimiters
    '{1'b1, 1'b0, 10'h000, 10'h3FF, 1'b1, '{10'h3FF, 10'h3FF}},
    '{1'b1, 1'b1, 10'h000, 10'h003, 1'b1, '{10'h003, 10'h003}},  // engine code three wins
    '{1'b0, 1'b0, 10'h000, 10'h000, 1'b0, '{10'h000, 10'h000}},  // no first byte
    '{1'b1, 1'b1, 10'h155, 10'h2AA, 1'b0, '{10'h000, 10'h000}},
    '{1'b1, 1'b0, 10'h2AA, 10'h155, 1'b0, '{10'h000, 10'h000}},
    '{1'b1, 1'b0, 10'h3FF, 10'h3FF, 1'b0, '{10'h000, 10'h000}},
    '{1'b1, 1'b1, 10'h000, 10'h3FF, 1'b1, '{10'h3F5, 10'h3F5}},
    '{1'b1, 1'b0, 10'h2AA, 10'h000, 1'b1, '{10'h2AA, 10'h000}}
  };

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  // Stimulus words, typed checks and expected flag sets
  in_item_t  stim [$];
  bit        stim_chk [$];
  out_item_t stim_want [$];
  out_item_t flags_due [$];
  string     dir_text [DIR_N];

  int unsigned accepted_n = 0;
  int unsigned results_n  = 0;
  int unsigned errors     = 0;
  int unsigned stall_cycles = 0;
  bit          calm = 1'b0;
  bit          sink_hold = 1'b0;

  // Parser state mirror
  logic [7:0]        tok_buf [TOK_CHARS];
  int unsigned       tok_len = 0;
  bit                tok_long = 1'b0;
  logic [FLAG_W-1:0] parse_set = '0;
  logic [FLAG_W-1:0] side_set = '0;
  bit                parse_engine = 1'b0;

  robots_meta_directive_parser_top #(.TOKEN_CHARS(TOK_CHARS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  function automatic logic [7:0] kw_char(kw_t k, int i);
    return KW_TXT[k][8*(KW_LEN[k]-1-i) +: 8];
  endfunction

  function automatic string kw_string(kw_t k);
    string s;
    s = "";
    for (int j = 0; j < KW_LEN[k]; j++) s = $sformatf("%s%c", s, kw_char(k, j));
    return s;
  endfunction

  function automatic bit is_separator(logic [7:0] b);
    for (int j = 0; j < 7; j++) if (b == SEPS[j]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [FLAG_W-1:0] put_code(logic [FLAG_W-1:0] f, int i, logic [1:0] c);
    f[2*i +: 2] = c;
    return f;
  endfunction

  // Deny keeps an allow, anything else becomes disallow
  function automatic logic [FLAG_W-1:0] deny_code(logic [FLAG_W-1:0] f, int i);
    return put_code(f, i, (f[2*i +: 2] == CODE_ALLOW) ? CODE_ALLOW : CODE_DISALLOW);
  endfunction

  // Engine codes that are set override the robots codes
  function automatic logic [FLAG_W-1:0] merge_sets(logic [FLAG_W-1:0] rb,
                                                    logic [FLAG_W-1:0] en);
    for (int i = 0; i < FLAG_COUNT; i++)
      if (en[2*i +: 2] != CODE_UNSET) rb[2*i +: 2] = en[2*i +: 2];
    return rb;
  endfunction

  function automatic bit token_matches(kw_t k);
    logic [7:0] c;
    if (tok_long || tok_len != KW_LEN[k]) return 1'b0;
    for (int i = 0; i < KW_LEN[k]; i++) begin
      c = tok_buf[i];
      if (c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_GAP;
      if (c != kw_char(k, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Close the current token and apply its directive
  function automatic void close_token();
    kw_t hit;
    hit = KW_NOMATCH;
    for (int k = KW_ALL; k <= KW_NOCAT; k++)
      if (hit == KW_NOMATCH && token_matches(kw_t'(k))) hit = kw_t'(k);
    case (hit)
      KW_ALL: begin
        parse_set = put_code(parse_set, FLAG_INDEX, CODE_ALLOW);
        parse_set = put_code(parse_set, FLAG_FOLLOW, CODE_ALLOW);
      end
      KW_NONE: begin
        parse_set = deny_code(parse_set, FLAG_INDEX);
        parse_set = deny_code(parse_set, FLAG_FOLLOW);
      end
      KW_INDEX:     parse_set = put_code(parse_set, FLAG_INDEX, CODE_ALLOW);
      KW_NOINDEX:   parse_set = deny_code(parse_set, FLAG_INDEX);
      KW_FOLLOW:    parse_set = put_code(parse_set, FLAG_FOLLOW, CODE_ALLOW);
      KW_NOFOLLOW:  parse_set = deny_code(parse_set, FLAG_FOLLOW);
      KW_ARCHIVE:   parse_set = put_code(parse_set, FLAG_ARCHIVE, CODE_ALLOW);
      KW_NOARCHIVE: parse_set = deny_code(parse_set, FLAG_ARCHIVE);
      KW_NODIR:     parse_set = deny_code(parse_set, FLAG_DIR);
      KW_NOCAT:     parse_set = deny_code(parse_set, FLAG_CATALOG);
      default: ;
    endcase
    tok_len  = 0;
    tok_long = 1'b0;
  endfunction

  // Advance the mirror by one word; returns 1 when the word closes a value
  function automatic bit parse_byte(input in_item_t w, output out_item_t r);
    logic [FLAG_W-1:0] merged;
    r = '0;
    if (w.first_byte) begin
      parse_engine = w.mode;
      parse_set    = w.mode ? w.engine_prior : w.robots_prior;
      side_set     = w.mode ? w.robots_prior : w.engine_prior;
      tok_len      = 0;
      tok_long     = 1'b0;
    end
    if (is_separator(w.data_byte)) begin
      close_token();
    end else if (tok_len < TOK_CHARS) begin
      tok_buf[tok_len] = w.data_byte;
      tok_len++;
    end else begin
      tok_long = 1'b1;
    end
    if (!w.last_byte) return 1'b0;
    close_token();
    if (parse_engine) begin
      merged   = merge_sets(side_set, parse_set);
      side_set = merged;
      r.robots_flags = merged;
      r.engine_flags = parse_set;
    end else begin
      merged    = merge_sets(parse_set, side_set);
      parse_set = merged;
      r.robots_flags = merged;
      r.engine_flags = side_set;
    end
    return 1'b1;
  endfunction

  function automatic logic [FLAG_W-1:0] pick_flags();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return FLAG_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // One random value: mostly directive lists, some raw noise
  task automatic add_value(input bit tidy);
    logic [7:0]        txt [$];
    in_item_t          w;
    kw_t               k;
    int                ntok, sel, n;
    logic [7:0]        c;
    bit                md;
    logic [FLAG_W-1:0] rp, ep;
    md = 1'($urandom_range(0, 1));
    rp = pick_flags();
    ep = pick_flags();
    if (tidy) begin
      ntok = $urandom_range(0, 4);
      for (int t = 0; t < ntok; t++) begin
        if (t > 0 || $urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 2)) txt.push_back(SEPS[$urandom_range(0, 6)]);
        sel = $urandom_range(0, 9);
        k   = kw_t'($urandom_range(KW_ALL, KW_NOCAT));
        n   = KW_LEN[k];
        if (sel >= 8) begin
          // random letters, or any non-delimiter bytes; up to long tokens
          repeat ($urandom_range(1, 12)) begin
            if (sel == 8) begin
              c = 8'h41 + 8'($urandom_range(0, 25));
              if ($urandom_range(0, 1)) c = c + CASE_GAP;
            end else begin
              do c = 8'($urandom_range(0, 255)); while (is_separator(c));
            end
            txt.push_back(c);
          end
        end else begin
          // keyword in mixed case, sometimes cut short or stretched
          if (sel == 6) n--;
          for (int j = 0; j < n; j++) begin
            c = kw_char(k, j);
            if ($urandom_range(0, 1)) c = c + CASE_GAP;
            txt.push_back(c);
          end
          if (sel == 7) txt.push_back(8'h41 + 8'($urandom_range(0, 25)));
        end
      end
      if ($urandom_range(0, 4) == 0) txt.push_back(SEPS[$urandom_range(0, 6)]);
    end else begin
      repeat ($urandom_range(1, 6))
        txt.push_back(($urandom_range(0, 3) == 0) ? SEPS[$urandom_range(0, 6)]
                                                  : 8'($urandom_range(0, 255)));
    end
    if (txt.size() == 0) txt.push_back(CH_NUL);
    for (int j = 0; j < txt.size(); j++) begin
      w.data_byte    = txt[j];
      w.mode         = (j == 0) ? md : 1'($urandom_range(0, 1));
      w.robots_prior = (j == 0) ? rp : FLAG_W'($urandom_range(0, 1023));
      w.engine_prior = (j == 0) ? ep : FLAG_W'($urandom_range(0, 1023));
      if (tidy) begin
        w.first_byte = (j == 0) && ($urandom_range(0, 19) != 0);
        w.last_byte  = (j == txt.size() - 1);
      end else begin
        w.first_byte = ($urandom_range(0, 3) == 0);
        w.last_byte  = ($urandom_range(0, 3) == 0);
      end
      stim.push_back(w);
      stim_chk.push_back(1'b0);
      stim_want.push_back('0);
    end
  endtask

  task automatic send_word(input in_item_t w);
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender: builds the word list, then offers it with random idle bursts
  initial begin : feed
    in_item_t w;
    int       n;
    bit       bursty;
    item_valid <= 1'b0;
    item       <= '0;
    dir_text = '{"", "all", "NONE", "Index", "noindex", "FOLLOW", "nofollow", "ArChIvE",
                 "NOARCHIVE", kw_string(KW_NODIR), kw_string(KW_NOCAT), "NOARCHIVEX",
                 "all;noindex,\tnofollow\015\n", "all", "x", "index", "none  ,, all",
                 "NOFOLLOWS", "noarchiv", "none", "follow"};
    for (int r = 0; r < DIR_N; r++) begin
      n = dir_text[r].len();
      for (int j = 0; j < ((n == 0) ? 1 : n); j++) begin
        w.data_byte    = (n == 0) ? CH_NUL : dir_text[r][j];
        w.first_byte   = DIR_TAB[r].first_on && (j == 0);
        w.last_byte    = (j == ((n == 0) ? 0 : n - 1));
        w.mode         = DIR_TAB[r].mode;
        w.robots_prior = DIR_TAB[r].rp;
        w.engine_prior = DIR_TAB[r].ep;
        stim.push_back(w);
        stim_chk.push_back(DIR_TAB[r].chk && w.last_byte);
        stim_want.push_back(DIR_TAB[r].want);
      end
    end
    while (stim.size() < ITEMS_TARGET) add_value($urandom_range(0, 19) < 17);

    bursty = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    for (int i = 0; i < stim.size(); i++) begin
      calm = (i >= stim.size() - CALM_TAIL);
      if (i % 120 == 0) bursty = 1'($urandom_range(0, 1));
      // drain pause: hold the next word until every result is back
      if (i == PAUSE_AT) begin
        item_valid <= 1'b0;
        do @(posedge clk); while (flags_due.size() != 0);
      end
      if (!calm && !sink_hold && bursty && $urandom_range(0, 5) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      send_word(stim[i]);
    end
    item_valid <= 1'b0;
    do @(posedge clk); while (flags_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words and %0d results: all directives, long and empty tokens,",
             accepted_n, results_n);
    $display("both modes, noise, a %0d-cycle result stall and a drain pause", HOLD_SPAN);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stall bursts plus one long hold-off
  initial begin : sink
    bit held;
    bit bursty;
    held   = 1'b0;
    bursty = 1'b1;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && accepted_n >= HOLD_AT) begin
        held = 1'b1;
        sink_hold = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_SPAN) @(posedge clk);
        sink_hold = 1'b0;
      end else if (!calm && bursty && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      if ($urandom_range(0, 40) == 0) bursty = !bursty;
    end
  end

  // Predict on accepted words, check accepted results, watch for a hang
  always @(posedge clk) begin : watch
    out_item_t due;
    out_item_t fresh;
    if (!rst) begin
      if (item_valid && item_ready) begin
        if (parse_byte(item, fresh))
          flags_due.push_back(stim_chk[accepted_n] ? stim_want[accepted_n] : fresh);
        accepted_n++;
      end
      if (result_valid && result_ready) begin
        results_n++;
        if (flags_due.size() == 0) begin
          errors++;
          $display("%0t: result word %h with nothing expected", $time, result);
        end else begin
          due = flags_due.pop_front();
          if (result.robots_flags !== due.robots_flags) begin
            errors++;
            $display("%0t: robots_flags expected %h actual %h", $time,
                     due.robots_flags, result.robots_flags);
          end
          if (result.engine_flags !== due.engine_flags) begin
            errors++;
            $display("%0t: engine_flags expected %h actual %h", $time,
                     due.engine_flags, result.engine_flags);
          end
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        stall_cycles = 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results pending", $time,
                 stall_cycles, flags_due.size());
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

endmodule
